@@ hw/rtl/sched_tick_vruntime_accounting_core_assert.svh @@
// Assertion macros for the checker file of the tick accounting core.
// Depends on nothing; included by the checker module.
`ifndef SCHED_TICK_VRUNTIME_ACCOUNTING_CORE_ASSERT_SVH
`define SCHED_TICK_VRUNTIME_ACCOUNTING_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define STVAC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("stvac assertion failed");

// Clocked assertion that is also checked during reset.
`define STVAC_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("stvac reset assertion failed");

`endif

@@ hw/rtl/stvac_pkg.sv @@
// Shared types, constants and functions of the tick accounting core.
// Depends on nothing; imported by the interfaces and all modules but the checker.
package stvac_pkg;

  localparam int unsigned TimeW  = 64;
  localparam int unsigned Nice0W = 21;
  localparam int unsigned WghtW  = 32;
  localparam int unsigned ClsW   = 2;
  // The product elapsed * nice0 is as wide as both factors together.
  localparam int unsigned ProdW  = TimeW + Nice0W;
  localparam int unsigned HalfW  = TimeW / 2;
  localparam int unsigned PartW  = HalfW + Nice0W;

  localparam logic [ClsW-1:0] CLS_FAIR = 2'd0;
  localparam logic [ClsW-1:0] CLS_RT   = 2'd1;

  // Configuration register indexes.
  localparam logic CFG_NICE0    = 1'b0;
  localparam logic CFG_RT_SLICE = 1'b1;

  localparam logic [Nice0W-1:0] NICE0_RESET    = 21'd1024;
  localparam logic [TimeW-1:0]  RT_SLICE_RESET = 64'd10000000;

  // Accounting record as it travels down the pipeline.
  typedef struct packed {
    logic [TimeW-1:0] run_total;
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] virt_run;
    logic [TimeW-1:0] slice_used;
    logic             want;
    logic             upd_virt;
  } rec_t;

  // Unsigned add that saturates at all ones.
  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

endpackage

@@ hw/rtl/stvac_if.sv @@
// Valid/ready channel interfaces for tick items and accounting results.
// Depends on stvac_pkg for the field widths.
interface stvac_in_if import stvac_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TimeW-1:0]    now_time;
  logic [TimeW-1:0]    start_time;
  logic [TimeW-1:0]    run_total_in;
  logic [TimeW-1:0]    virt_run_in;
  logic [TimeW-1:0]    slice_used_in;
  logic [WghtW-1:0]    thread_weight;
  logic [ClsW-1:0]     thread_class;
  logic                has_thread;
  logic                is_idle;
  logic                others_runnable;

  modport source (output valid, now_time, start_time, run_total_in, virt_run_in,
                  slice_used_in, thread_weight, thread_class, has_thread, is_idle,
                  others_runnable, input ready);
  modport sink (input valid, now_time, start_time, run_total_in, virt_run_in,
                slice_used_in, thread_weight, thread_class, has_thread, is_idle,
                others_runnable, output ready);
endinterface

interface stvac_out_if import stvac_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] run_total_out;
  logic [TimeW-1:0] start_time_out;
  logic [TimeW-1:0] virt_run_out;
  logic [TimeW-1:0] slice_used_out;
  logic             want_resched;

  modport source (output valid, run_total_out, start_time_out, virt_run_out,
                  slice_used_out, want_resched, input ready);
  modport sink (input valid, run_total_out, start_time_out, virt_run_out,
                slice_used_out, want_resched, output ready);
endinterface

@@ hw/rtl/stvac_front.sv @@
// Front stages: elapsed time, runtime and slice updates, preemption flags
// and the elapsed * nice0 product. Depends on stvac_pkg.
module stvac_front import stvac_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [TimeW-1:0]  now_i,
  input  logic [TimeW-1:0]  start_i,
  input  logic [TimeW-1:0]  run_i,
  input  logic [TimeW-1:0]  virt_i,
  input  logic [TimeW-1:0]  slice_i,
  input  logic [WghtW-1:0]  weight_i,
  input  logic [ClsW-1:0]   cls_i,
  input  logic              has_i,
  input  logic              idle_i,
  input  logic              others_i,
  input  logic [Nice0W-1:0] nice0_i,
  input  logic [TimeW-1:0]  rt_slice_i,
  output logic              valid_o,
  output rec_t              rec_o,
  output logic [ProdW-1:0]  prod_o,
  output logic [WghtW-1:0]  divisor_o
);

  // Stage 1 registers.
  logic             v1_q;
  logic [TimeW-1:0] now1_q, start1_q, run1_q, virt1_q, slice1_q, el1_q;
  logic [WghtW-1:0] w1_q;
  logic [ClsW-1:0]  cls1_q;
  logic             has1_q, idle1_q, oth1_q;

  // Stage 2 registers.
  logic             v2_q;
  rec_t             rec2_q, rec2_d;
  logic             rtchk2_q, rtchk2_d;
  logic [PartW-1:0] plo2_q, phi2_q;
  logic [WghtW-1:0] w2_q;

  // Stage 3 registers.
  logic             v3_q;
  rec_t             rec3_q, rec3_d;
  logic [ProdW-1:0] prod3_q;
  logic [WghtW-1:0] w3_q;

  logic act1;

  // Elapsed time, zero when the thread has no start time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      now1_q   <= now_i;
      start1_q <= start_i;
      run1_q   <= run_i;
      virt1_q  <= virt_i;
      slice1_q <= slice_i;
      w1_q     <= weight_i;
      cls1_q   <= cls_i;
      has1_q   <= has_i;
      idle1_q  <= idle_i;
      oth1_q   <= others_i;
      el1_q    <= (start_i == '0) ? '0 : now_i - start_i;
    end
  end

  // Record update for an accounted (present, non-idle) thread.
  assign act1 = has1_q & ~idle1_q;

  always_comb begin
    rec2_d            = '0;
    rec2_d.run_total  = act1 ? sat_add(run1_q, el1_q) : run1_q;
    rec2_d.start_time = act1 ? now1_q : start1_q;
    rec2_d.virt_run   = virt1_q;
    rec2_d.slice_used = (act1 && cls1_q == CLS_RT) ? sat_add(slice1_q, el1_q) : slice1_q;
    rec2_d.upd_virt   = act1 && cls1_q == CLS_FAIR;
    rec2_d.want       = (has1_q & idle1_q & oth1_q) |
                        (act1 && cls1_q == CLS_FAIR && oth1_q && el1_q != '0);
    rtchk2_d          = act1 && cls1_q == CLS_RT && oth1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  // Partial products of the elapsed time halves with nice0.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rec2_q   <= rec2_d;
      rtchk2_q <= rtchk2_d;
      plo2_q   <= PartW'(el1_q[HalfW-1:0]) * PartW'(nice0_i);
      phi2_q   <= PartW'(el1_q[TimeW-1:HalfW]) * PartW'(nice0_i);
      w2_q     <= (w1_q == '0) ? WghtW'(1) : w1_q;
    end
  end

  // Slice expiry check and the full product.
  always_comb begin
    rec3_d      = rec2_q;
    rec3_d.want = rec2_q.want | (rtchk2_q && rec2_q.slice_used >= rt_slice_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rec3_q  <= rec3_d;
      prod3_q <= {phi2_q, {HalfW{1'b0}}} + ProdW'(plo2_q);
      w3_q    <= w2_q;
    end
  end

  assign valid_o   = v3_q;
  assign rec_o     = rec3_q;
  assign prod_o    = prod3_q;
  assign divisor_o = w3_q;

endmodule

@@ hw/rtl/stvac_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, that carries the
// accounting record alongside. Depends on stvac_pkg.
module stvac_div import stvac_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  rec_t              rec_i,
  input  logic [ProdW-1:0]  dividend_i,
  input  logic [WghtW-1:0]  divisor_i,
  output logic              valid_o,
  output rec_t              rec_o,
  output logic [ProdW-1:0]  quot_o
);

  // Entry 0 is the stage input; entry i holds the register after stage i.
  logic             v_q   [ProdW+1];
  rec_t             rec_q [ProdW+1];
  logic [ProdW-1:0] dq_q  [ProdW+1];
  logic [WghtW-1:0] rem_q [ProdW+1];
  logic [WghtW-1:0] w_q   [ProdW+1];

  always_comb begin
    v_q[0]   = valid_i;
    rec_q[0] = rec_i;
    dq_q[0]  = dividend_i;
    rem_q[0] = '0;
    w_q[0]   = divisor_i;
  end

  for (genvar i = 0; i < ProdW; i++) begin : g_stage
    logic [WghtW:0]   trial, diff;
    logic             ge;
    logic [WghtW-1:0] rem_d;

    // Bring in the next dividend bit and try to subtract the divisor.
    always_comb begin
      trial = {rem_q[i], dq_q[i][ProdW-1]};
      diff  = trial - {1'b0, w_q[i]};
      ge    = trial >= {1'b0, w_q[i]};
      rem_d = ge ? diff[WghtW-1:0] : trial[WghtW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rec_q[i+1] <= rec_q[i];
        dq_q[i+1]  <= {dq_q[i][ProdW-2:0], ge};
        rem_q[i+1] <= rem_d;
        w_q[i+1]   <= w_q[i];
      end
    end
  end

  assign valid_o = v_q[ProdW];
  assign rec_o   = rec_q[ProdW];
  assign quot_o  = dq_q[ProdW];

endmodule

@@ hw/rtl/stvac_back.sv @@
// Final stage: clamps the scaled delta and adds it to the virtual runtime.
// Depends on stvac_pkg.
module stvac_back import stvac_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  rec_t             rec_i,
  input  logic [ProdW-1:0] quot_i,
  output logic             valid_o,
  output rec_t             rec_o
);

  logic             v_q;
  rec_t             rec_q, rec_d;
  logic [TimeW-1:0] delta;

  // A quotient beyond 64 bits saturates the delta.
  always_comb begin
    delta = (|quot_i[ProdW-1:TimeW]) ? {TimeW{1'b1}} : quot_i[TimeW-1:0];
    rec_d = rec_i;
    if (rec_i.upd_virt) begin
      rec_d.virt_run = sat_add(rec_i.virt_run, delta);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rec_q <= rec_d;
    end
  end

  assign valid_o = v_q;
  assign rec_o   = rec_q;

endmodule

@@ hw/rtl/stvac_skid.sv @@
// Output register with a skid entry, so the pipeline stall is registered.
// Depends on stvac_pkg.
module stvac_skid import stvac_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  rec_t rec_i,
  output logic full_o,
  output logic valid_o,
  input  logic ready_i,
  output rec_t rec_o
);

  logic out_v_q, skid_v_q;
  rec_t out_q, skid_q;

  // Control: the skid entry fills only when the output is held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || ready_i) begin
      out_v_q  <= skid_v_q | valid_i;
      skid_v_q <= 1'b0;
    end else if (valid_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || ready_i) begin
      out_q <= skid_v_q ? skid_q : rec_i;
    end else if (valid_i) begin
      skid_q <= rec_i;
    end
  end

  assign full_o  = skid_v_q;
  assign valid_o = out_v_q;
  assign rec_o   = out_q;

endmodule

@@ hw/rtl/sched_tick_vruntime_accounting_core.sv @@
// Tick accounting core: a timer tick plus the running thread's record in,
// the updated record and a preemption request out.
//
// The input channel in_i carries one tick transaction: the times, the
// thread record, its weight and class and the runqueue flags. The output
// channel out_o returns exactly one result transaction per tick, in order.
// Both are valid/ready; a transaction moves when valid and ready are high.
// nice0_weight (index 0) and rt_slice_ns (index 1) are written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i while no tick is in flight.
// The divider pipeline sets the latency; from acceptance to out_o a tick
// passes three front stages, 85 stages of a one-bit-per-stage divider that
// forms elapsed * nice0 / weight, one final add stage and the output
// register. Throughput is one tick per cycle unless out_o stalls.
// Reset clears all valid bits and loads the register defaults (1024 and
// 10 ms). When out_o is stalled, a skid entry takes one more result and then
// the whole pipeline holds; in_i.ready drops the cycle after, from a register.
module sched_tick_vruntime_accounting_core import stvac_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  stvac_in_if.sink         in_i,
  stvac_out_if.source      out_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [TimeW-1:0] cfg_wdata_i
);

  logic [Nice0W-1:0] nice0_q;
  logic [TimeW-1:0]  rt_slice_q;
  logic              en, skid_full;

  logic              f_v, d_v, b_v;
  rec_t              f_rec, d_rec, b_rec, o_rec;
  logic [ProdW-1:0]  f_prod, d_quot;
  logic [WghtW-1:0]  f_div;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nice0_q    <= NICE0_RESET;
      rt_slice_q <= RT_SLICE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NICE0:    nice0_q    <= cfg_wdata_i[Nice0W-1:0];
        CFG_RT_SLICE: rt_slice_q <= cfg_wdata_i;
        default:      nice0_q    <= nice0_q;
      endcase
    end
  end

  // The pipeline advances whenever the skid entry is free.
  assign en         = ~skid_full;
  assign in_i.ready = en;

  stvac_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_i.valid),
    .now_i      (in_i.now_time),
    .start_i    (in_i.start_time),
    .run_i      (in_i.run_total_in),
    .virt_i     (in_i.virt_run_in),
    .slice_i    (in_i.slice_used_in),
    .weight_i   (in_i.thread_weight),
    .cls_i      (in_i.thread_class),
    .has_i      (in_i.has_thread),
    .idle_i     (in_i.is_idle),
    .others_i   (in_i.others_runnable),
    .nice0_i    (nice0_q),
    .rt_slice_i (rt_slice_q),
    .valid_o    (f_v),
    .rec_o      (f_rec),
    .prod_o     (f_prod),
    .divisor_o  (f_div)
  );

  stvac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (f_v),
    .rec_i      (f_rec),
    .dividend_i (f_prod),
    .divisor_i  (f_div),
    .valid_o    (d_v),
    .rec_o      (d_rec),
    .quot_o     (d_quot)
  );

  stvac_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_v),
    .rec_i   (d_rec),
    .quot_i  (d_quot),
    .valid_o (b_v),
    .rec_o   (b_rec)
  );

  stvac_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_v & en),
    .rec_i   (b_rec),
    .full_o  (skid_full),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .rec_o   (o_rec)
  );

  assign out_o.run_total_out  = o_rec.run_total;
  assign out_o.start_time_out = o_rec.start_time;
  assign out_o.virt_run_out   = o_rec.virt_run;
  assign out_o.slice_used_out = o_rec.slice_used;
  assign out_o.want_resched   = o_rec.want;

endmodule

@@ hw/rtl/stvac_chk.sv @@
// Port-level checker for the tick accounting core, bound to the top level.
// Depends on the assertion macro header.
`include "sched_tick_vruntime_accounting_core_assert.svh"

module stvac_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_run_i,
  input logic        out_want_i
);

  // A held result keeps its valid and its payload.
  `STVAC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)
  `STVAC_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(out_run_i) && $stable(out_want_i))
  // Backpressure on the input only comes from a full output side.
  `STVAC_ASSERT(a_stall_full, clk_i, rst_ni, !in_ready_i |-> out_valid_i)
  // Taking a result always frees the skid entry.
  `STVAC_ASSERT(a_take_frees, clk_i, rst_ni, out_valid_i && out_ready_i |=> in_ready_i)
  // Nothing is offered while reset is held.
  `STVAC_ASSERT_RST(a_rst_idle, clk_i, !rst_ni |-> !out_valid_i)

endmodule

bind sched_tick_vruntime_accounting_core stvac_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_run_i   (out_o.run_total_out),
  .out_want_i  (out_o.want_resched)
);

@@ tb/tb_sched_tick_vruntime_accounting_core.sv @@
// Testbench for the tick accounting core: drives tick transactions and
// configuration writes, predicts each updated record and checks it in order.
// Depends on stvac_pkg, the stvac channel interfaces and the core itself.
`timescale 1ns / 100ps

module tb_sched_tick_vruntime_accounting_core;
  import stvac_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 120;
  localparam logic [TimeW-1:0] AllOnes = {TimeW{1'b1}};

  typedef struct packed {
    logic [TimeW-1:0] now_time;
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] run_total;
    logic [TimeW-1:0] virt_run;
    logic [TimeW-1:0] slice_used;
    logic [WghtW-1:0] weight;
    logic [ClsW-1:0]  cls;
    logic             has_thread;
    logic             is_idle;
    logic             others;
  } tick_t;

  typedef struct packed {
    logic [TimeW-1:0] run_total;
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] virt_run;
    logic [TimeW-1:0] slice_used;
    logic             want;
  } acct_t;

  // Keeps the register copy and the queue of records the core still owes.
  class tick_account_board;
    logic [Nice0W-1:0] nice0;
    logic [TimeW-1:0]  rt_slice;
    acct_t             owed_records[$];
    bit                failed;

    function new();
      nice0    = NICE0_RESET;
      rt_slice = RT_SLICE_RESET;
      failed   = 0;
    endfunction

    function automatic logic [TimeW-1:0] add_sat(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
      logic [TimeW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TimeW] ? AllOnes : s[TimeW-1:0];
    endfunction

    // Virtual runtime growth: quotient and remainder parts scaled separately.
    function automatic logic [TimeW-1:0] vrun_growth(logic [TimeW-1:0] elapsed,
                                                     logic [WghtW-1:0] weight);
      logic [TimeW-1:0] w, q, r, lo;
      logic [ProdW-1:0] hi;
      if (elapsed == 0 || nice0 == 0) return 0;
      w  = (weight == 0) ? 64'd1 : {32'd0, weight};
      q  = elapsed / w;
      r  = elapsed % w;
      hi = {{Nice0W{1'b0}}, q} * {{TimeW{1'b0}}, nice0};
      if (hi[ProdW-1:TimeW] != 0) return AllOnes;
      lo = (r * {43'd0, nice0}) / w;
      return add_sat(hi[TimeW-1:0], lo);
    endfunction

    function automatic acct_t account_tick(tick_t t);
      acct_t            a;
      logic [TimeW-1:0] elapsed;
      a.run_total  = t.run_total;
      a.start_time = t.start_time;
      a.virt_run   = t.virt_run;
      a.slice_used = t.slice_used;
      a.want       = 1'b0;
      if (t.has_thread && t.is_idle) begin
        a.want = t.others;
      end else if (t.has_thread) begin
        elapsed      = (t.start_time == 0) ? 64'd0 : t.now_time - t.start_time;
        a.run_total  = add_sat(t.run_total, elapsed);
        a.start_time = t.now_time;
        if (t.cls == CLS_FAIR) begin
          a.virt_run = add_sat(t.virt_run, vrun_growth(elapsed, t.weight));
          a.want     = t.others && (elapsed != 0);
        end else if (t.cls == CLS_RT) begin
          a.slice_used = add_sat(t.slice_used, elapsed);
          a.want       = t.others && (a.slice_used >= rt_slice);
        end
      end
      return a;
    endfunction

    function void note_tick(tick_t t);
      owed_records.push_back(account_tick(t));
    endfunction

    function void check_record(acct_t got);
      acct_t exp;
      if (owed_records.size() == 0) begin
        $error("unexpected result transaction");
        failed = 1;
        return;
      end
      exp = owed_records.pop_front();
      if (got.run_total !== exp.run_total) begin
        $error("run_total_out exp %h got %h", exp.run_total, got.run_total);
        failed = 1;
      end
      if (got.start_time !== exp.start_time) begin
        $error("start_time_out exp %h got %h", exp.start_time, got.start_time);
        failed = 1;
      end
      if (got.virt_run !== exp.virt_run) begin
        $error("virt_run_out exp %h got %h", exp.virt_run, got.virt_run);
        failed = 1;
      end
      if (got.slice_used !== exp.slice_used) begin
        $error("slice_used_out exp %h got %h", exp.slice_used, got.slice_used);
        failed = 1;
      end
      if (got.want !== exp.want) begin
        $error("want_resched exp %b got %b", exp.want, got.want);
        failed = 1;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_idx;
  logic [TimeW-1:0] cfg_wdata;
  bit               calm;
  bit               hold_req;
  int unsigned      hold_cnt;
  int unsigned      cycles;

  tick_account_board board;

  stvac_in_if  tick_if ();
  stvac_out_if acct_if ();

  sched_tick_vruntime_accounting_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (tick_if.sink),
    .out_o       (acct_if.source),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Clock with a 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side backpressure: random stalls, calm stretches and one long hold.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      acct_if.ready <= 1'b0;
      hold_cnt = 0;
    end else if (hold_req) begin
      acct_if.ready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= 400) begin
        hold_req = 0;
        hold_cnt = 0;
      end
    end else begin
      acct_if.ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  // Every accepted result transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && acct_if.valid && acct_if.ready) begin
      board.check_record({acct_if.run_total_out, acct_if.start_time_out,
                          acct_if.virt_run_out, acct_if.slice_used_out,
                          acct_if.want_resched});
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [TimeW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(logic idx, logic [TimeW-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_NICE0) board.nice0 = value[Nice0W-1:0];
    else board.rt_slice = value;
  endtask

  // Offers one tick and waits for its transaction; may leave a random gap after.
  task automatic send_tick(tick_t t);
    tick_if.valid           <= 1'b1;
    tick_if.now_time        <= t.now_time;
    tick_if.start_time      <= t.start_time;
    tick_if.run_total_in    <= t.run_total;
    tick_if.virt_run_in     <= t.virt_run;
    tick_if.slice_used_in   <= t.slice_used;
    tick_if.thread_weight   <= t.weight;
    tick_if.thread_class    <= t.cls;
    tick_if.has_thread      <= t.has_thread;
    tick_if.is_idle         <= t.is_idle;
    tick_if.others_runnable <= t.others;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
    board.note_tick(t);
    if (!calm && $urandom_range(99) < 7) begin
      tick_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic idle_tick_side();
    tick_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic tick_t random_tick();
    tick_t            t;
    logic [TimeW-1:0] gap;
    int unsigned      pick;
    pick = $urandom_range(99);
    gap  = (pick < 70) ? {32'd0, $urandom_range(0, 50000000)} :
           (pick < 85) ? (rand64() >> 16) : rand64();
    t.start_time = ($urandom_range(9) == 0) ? 64'd0 : rand64();
    t.now_time   = t.start_time + gap;
    t.run_total  = ($urandom_range(7) == 0) ? AllOnes - {32'd0, $urandom_range(0, 1000)}
                                            : rand64();
    t.virt_run   = ($urandom_range(7) == 0) ? AllOnes - {32'd0, $urandom_range(0, 1000)}
                                            : rand64() >> $urandom_range(0, 63);
    t.slice_used = ($urandom_range(3) == 0) ? board.rt_slice - {32'd0, $urandom}
                                            : rand64() >> $urandom_range(0, 63);
    case ($urandom_range(3))
      0: t.weight = $urandom_range(0, 2);
      1: t.weight = $urandom_range(15, 88761);
      default: t.weight = $urandom;
    endcase
    t.cls        = ClsW'($urandom_range(0, 3));
    t.has_thread = $urandom_range(9) != 0;
    t.is_idle    = $urandom_range(9) == 0;
    t.others     = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // Directed ticks: field extremes, every class and the named corner cases.
  task automatic run_directed();
    tick_t t;
    t = '0;
    t.has_thread = 1'b1;
    t.others     = 1'b1;
    // Fair thread, ordinary tick.
    t.start_time = 64'd1000; t.now_time = 64'd4001000; t.weight = 32'd1024;
    send_tick(t);
    // Not started yet: zero elapsed, no preemption.
    t.start_time = 64'd0;
    send_tick(t);
    // Zero weight read as one, and all-ones weight.
    t.start_time = 64'd5; t.weight = 32'd0;
    send_tick(t);
    t.weight = 32'hFFFF_FFFF; t.now_time = AllOnes;
    send_tick(t);
    // Quotient times nice0 overflows.
    t.start_time = 64'd1; t.weight = 32'd1; t.now_time = AllOnes;
    send_tick(t);
    // Saturating sums on the runtime and virtual runtime accumulators.
    t.run_total = AllOnes; t.virt_run = AllOnes - 64'd3; t.slice_used = AllOnes;
    t.weight = 32'd3;
    send_tick(t);
    // Time going backwards wraps.
    t = '0; t.has_thread = 1'b1; t.others = 1'b1;
    t.start_time = 64'd100; t.now_time = 64'd50; t.weight = 32'd7;
    send_tick(t);
    // Real-time thread below, at and above the slice.
    t.cls = CLS_RT; t.start_time = 64'd10; t.now_time = 64'd9999999;
    send_tick(t);
    t.now_time = 64'd10000010;
    send_tick(t);
    t.slice_used = AllOnes;
    send_tick(t);
    t.others = 1'b0;
    send_tick(t);
    // Other class and the unused class code account runtime only.
    t.slice_used = 0; t.others = 1'b1; t.cls = 2'd2;
    send_tick(t);
    t.cls = 2'd3;
    send_tick(t);
    // Idle thread with and without other work.
    t.is_idle = 1'b1;
    send_tick(t);
    t.others = 1'b0;
    send_tick(t);
    // No thread passes everything through, idle flag or not.
    t.has_thread = 1'b0; t.others = 1'b1; t.cls = CLS_FAIR;
    send_tick(t);
    t.is_idle = 1'b0; t.run_total = AllOnes; t.virt_run = AllOnes;
    t.now_time = AllOnes; t.weight = 32'hFFFF_FFFF;
    send_tick(t);
    // Fair thread with nothing else runnable.
    t.has_thread = 1'b1; t.others = 1'b0; t.run_total = 0; t.virt_run = 0;
    t.start_time = 64'd3; t.now_time = 64'd12345;
    send_tick(t);
  endtask

  task automatic wait_drained();
    idle_tick_side();
    while (board.owed_records.size() != 0) @(posedge clk);
  endtask

  // Stimulus: directed ticks, then random phases under changing registers.
  initial begin
    logic [Nice0W-1:0] nice0_set[5];
    logic [TimeW-1:0]  slice_set[5];
    board = new();
    cycles = 0;
    calm = 0;
    hold_req = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_NICE0;
    cfg_wdata = '0;
    tick_if.valid = 1'b0;
    tick_if.now_time = '0;
    tick_if.start_time = '0;
    tick_if.run_total_in = '0;
    tick_if.virt_run_in = '0;
    tick_if.slice_used_in = '0;
    tick_if.thread_weight = '0;
    tick_if.thread_class = CLS_FAIR;
    tick_if.has_thread = 1'b0;
    tick_if.is_idle = 1'b0;
    tick_if.others_runnable = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    nice0_set = '{21'd1024, 21'd1, 21'd1048576, 21'd0, 21'd1024};
    slice_set = '{64'd10000000, 64'd1, AllOnes, 64'd5000, 64'd10000000};
    nice0_set[4] = Nice0W'($urandom_range(1, 1048576));
    slice_set[4] = rand64() >> $urandom_range(0, 40);

    run_directed();
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_NICE0, {43'd0, nice0_set[ph]});
      write_reg(CFG_RT_SLICE, slice_set[ph]);
      for (int n = 0; n < 266; n++) begin
        if (ph == 1 && n == 20) hold_req = 1;
        calm = (ph == 2 && n >= 50 && n < 150);
        send_tick(random_tick());
        // The sender waits once for every outstanding result.
        if (ph == 3 && n == 100) wait_drained();
      end
      calm = 0;
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    if (!board.failed && board.owed_records.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sched_tick_vruntime_accounting_core.f @@
+incdir+hw/rtl
hw/rtl/stvac_pkg.sv
hw/rtl/stvac_if.sv
hw/rtl/stvac_front.sv
hw/rtl/stvac_div.sv
hw/rtl/stvac_back.sv
hw/rtl/stvac_skid.sv
hw/rtl/sched_tick_vruntime_accounting_core.sv
hw/rtl/stvac_chk.sv
tb/tb_sched_tick_vruntime_accounting_core.sv
